// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL file that carries checks (image_convolution_filter).
// Self-contained; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define ICF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ICF_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/icf_pkg.sv =====
// Shared constants, register codes and types of the image convolution filter.
// No dependencies.
`default_nettype none

package icf_pkg;

  localparam int PIX_W          = 8;
  localparam int COEF_W         = 16;
  localparam int KSIZE_W        = 2;
  localparam int CFG_DIM_W      = 11;
  localparam int ROW_W          = 10;
  localparam int MAX_HEIGHT     = 1024;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_KERNEL_DEF = 3;
  localparam int QUEUE_DEPTH    = 4;

  // Q8.8 datapath widths
  localparam int FRAC_W     = 8;
  localparam int ROUND_HALF = 128;
  localparam int PROD_W     = 24;
  localparam int ROWSUM_W   = 26;
  localparam int SUM_W      = 28;
  localparam int MAG_W      = 27;
  localparam int FILT_W     = 19;

  // configuration port
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  localparam logic [KSIZE_W-1:0]   KSIZE_RST  = 2'd3;
  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 11'd1024;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_KSIZE    = 3'd0,
    REG_COEF_TOP = 3'd1,
    REG_COEF_MID = 3'd2,
    REG_COEF_BOT = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5
  } icf_reg_e;

  // coef[i][j]: kernel row i, column j
  typedef logic [2:0][2:0][COEF_W-1:0] icf_coef_t;

  typedef struct packed {
    logic [KSIZE_W-1:0] ksize;
    icf_coef_t          coef;
  } icf_kern_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] width;
    logic [CFG_DIM_W-1:0] height;
  } icf_geom_t;

  // win[a][b]: pixel at row-a, col-b (clamped)
  typedef struct packed {
    logic                       last;
    logic [2:0][2:0][PIX_W-1:0] win;
  } icf_item_t;

endpackage

`default_nettype wire

// ===== hdl/icf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module icf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/icf_front.sv =====
// Front end: pixel intake, raster position, line store and 3x3 window.
// Uses icf_pkg and icf_ram.
`default_nettype none

module icf_front #(
  parameter int MAX_WIDTH = icf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire icf_pkg::icf_geom_t         geom_i,
  input  wire logic                       s_tvalid_i,
  output logic                            s_tready_o,
  input  wire logic [icf_pkg::PIX_W-1:0]  pixel_i,
  output logic                            push_o,
  input  wire logic                       full_i,
  output icf_pkg::icf_item_t              item_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > icf_pkg::CFG_DIM_W) ? CW + 1 : icf_pkg::CFG_DIM_W;
  localparam int PW = icf_pkg::PIX_W;
  localparam int DW = icf_pkg::CFG_DIM_W;

  logic [EW-1:0] w_raw, weff;
  logic [DW-1:0] heff;

  always_comb begin
    w_raw = EW'(geom_i.width);
    if (w_raw == '0) begin
      weff = EW'(1);
    end else if (w_raw > EW'(MAX_WIDTH)) begin
      weff = EW'(MAX_WIDTH);
    end else begin
      weff = w_raw;
    end
    if (geom_i.height == '0) begin
      heff = DW'(1);
    end else if (geom_i.height > DW'(icf_pkg::MAX_HEIGHT)) begin
      heff = DW'(icf_pkg::MAX_HEIGHT);
    end else begin
      heff = geom_i.height;
    end
  end

  logic [CW-1:0]               col_q;
  logic [icf_pkg::ROW_W-1:0]   row_q;
  logic                        col_wrap, row_wrap, s_fire, f1_fire;

  // F1 stage: request waiting for its line store word
  logic            f1_valid_q, f1_col0_q, f1_row0_q, f1_row1_q, f1_last_q, f1_byp_q;
  logic [PW-1:0]   f1_px_q;
  logic [CW-1:0]   f1_col_q;
  logic [2*PW-1:0] fwd_word_q;

  logic [2*PW-1:0] ram_rdata, word, wdata;
  logic [PW-1:0]   back1, back2;
  logic [2:0][PW-1:0]        newcol;
  logic [2:0][2:0][PW-1:0]   win_q, win_d;

  assign col_wrap   = (EW'(col_q) + EW'(1)) >= weff;
  assign row_wrap   = (DW'(row_q) + DW'(1)) >= heff;
  assign s_tready_o = !f1_valid_q || !full_i;
  assign s_fire     = s_tvalid_i && s_tready_o;
  assign f1_fire    = f1_valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      f1_valid_q <= 1'b0;
      f1_byp_q   <= 1'b0;
      win_q      <= '0;
    end else begin
      if (s_fire) begin
        f1_valid_q <= 1'b1;
        // the word written this edge is not yet visible to the read
        f1_byp_q   <= f1_fire && (f1_col_q == col_q);
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_wrap ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end else if (f1_fire) begin
        f1_valid_q <= 1'b0;
      end
      if (f1_fire) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      f1_px_q   <= pixel_i;
      f1_col_q  <= col_q;
      f1_col0_q <= (col_q == '0);
      f1_row0_q <= (row_q == '0);
      f1_row1_q <= (row_q == icf_pkg::ROW_W'(1));
      f1_last_q <= col_wrap && row_wrap;
    end
    if (f1_fire) begin
      fwd_word_q <= wdata;
    end
  end

  // word per column: [7:0] pixel of row-1, [15:8] pixel of row-2
  icf_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (f1_fire),
    .waddr_i (f1_col_q),
    .wdata_i (wdata),
    .re_i    (s_fire),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    word = f1_byp_q ? fwd_word_q : ram_rdata;
    if (f1_row0_q) begin
      back1 = f1_px_q;
      back2 = f1_px_q;
    end else if (f1_row1_q) begin
      back1 = word[PW-1:0];
      back2 = word[PW-1:0];
    end else begin
      back1 = word[PW-1:0];
      back2 = word[2*PW-1:PW];
    end
    wdata     = {back1, f1_px_q};
    newcol[0] = f1_px_q;
    newcol[1] = back1;
    newcol[2] = back2;
    for (int a = 0; a < 3; a++) begin
      if (f1_col0_q) begin
        win_d[a][0] = newcol[a];
        win_d[a][1] = newcol[a];
        win_d[a][2] = newcol[a];
      end else begin
        win_d[a][2] = win_q[a][1];
        win_d[a][1] = win_q[a][0];
        win_d[a][0] = newcol[a];
      end
    end
  end

  assign push_o      = f1_fire;
  assign item_o.win  = win_d;
  assign item_o.last = f1_last_q;

endmodule

`default_nettype wire

// ===== hdl/icf_queue.sv =====
// Small register FIFO between the front end and the arithmetic back end.
// No dependencies.
`default_nettype none

module icf_queue #(
  parameter int WIDTH = 73,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       pop_i,
  output logic      [WIDTH-1:0]           rdata_o,
  output logic                            full_o,
  output logic                            empty_o,
  output logic      [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [NW-1:0]    cnt_q;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= nxt(wr_q);
      end
      if (pop_i) begin
        rd_q <= nxt(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_q];
  assign full_o  = (cnt_q == NW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

`default_nettype wire

// ===== hdl/icf_back.sv =====
// Back end: tap products, adder tree, rounding and magnitude, output register.
// Uses icf_pkg.
`default_nettype none

module icf_back #(
  parameter int MAX_KERNEL = icf_pkg::MAX_KERNEL_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire icf_pkg::icf_kern_t          kern_i,
  input  wire logic                        q_valid_i,
  output logic                             q_pop_o,
  input  wire icf_pkg::icf_item_t          item_i,
  output logic                             m_tvalid_o,
  input  wire logic                        m_tready_i,
  output logic [icf_pkg::FILT_W-1:0]       filtered_o,
  output logic                             frame_end_o
);

  localparam int KW = icf_pkg::KSIZE_W;
  localparam int CF = icf_pkg::COEF_W;
  localparam int PX = icf_pkg::PIX_W;
  localparam int PR = icf_pkg::PROD_W;
  localparam int RS = icf_pkg::ROWSUM_W;
  localparam int SW = icf_pkg::SUM_W;
  localparam int MW = icf_pkg::MAG_W;

  logic [KW-1:0] keff;
  assign keff = (kern_i.ksize > KW'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : kern_i.ksize;

  logic out_rdy, b3_rdy, b2_rdy, b1_rdy, pop;
  logic b1_valid_q, b2_valid_q, b3_valid_q, out_valid_q;
  logic b1_last_q, b2_last_q, b3_last_q, out_last_q;

  logic signed [PR-1:0] prod_d [3][3];
  logic signed [PR-1:0] prod_q [3][3];
  logic signed [RS-1:0] rs_q [3];
  logic signed [SW-1:0] sum_q;
  logic [SW-1:0]        mag;
  logic [MW-1:0]        mag_r;
  logic [icf_pkg::FILT_W-1:0] filt_q;

  assign out_rdy = !out_valid_q || m_tready_i;
  assign b3_rdy  = !b3_valid_q || out_rdy;
  assign b2_rdy  = !b2_valid_q || b3_rdy;
  assign b1_rdy  = !b1_valid_q || b2_rdy;
  assign pop     = q_valid_i && b1_rdy;
  assign q_pop_o = pop;

  // window tap (a,b) meets coefficient (off-a, off-b), off = ceil(K/2)
  for (genvar a = 0; a < 3; a++) begin : g_row
    for (genvar b = 0; b < 3; b++) begin : g_col
      logic signed [CF-1:0]      c1, c2, c3, tap_coef;
      logic signed [PX:0]        pxs;
      logic signed [PX+CF-1:0]   full;

      assign c3 = kern_i.coef[2-a][2-b];
      if (a < 2 && b < 2) begin : g_k2
        assign c2 = kern_i.coef[1-a][1-b];
      end else begin : g_k2_off
        assign c2 = '0;
      end
      if (a == 1 && b == 1) begin : g_k1
        assign c1 = kern_i.coef[0][0];
      end else begin : g_k1_off
        assign c1 = '0;
      end

      always_comb begin
        unique case (keff)
          2'd3:    tap_coef = c3;
          2'd2:    tap_coef = c2;
          2'd1:    tap_coef = c1;
          default: tap_coef = '0;
        endcase
      end

      assign pxs          = signed'({1'b0, item_i.win[a][b]});
      assign full         = pxs * tap_coef;
      assign prod_d[a][b] = full[PR-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      b3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (b1_rdy)  b1_valid_q  <= pop;
      if (b2_rdy)  b2_valid_q  <= b1_valid_q;
      if (b3_rdy)  b3_valid_q  <= b2_valid_q;
      if (out_rdy) out_valid_q <= b3_valid_q;
    end
  end

  always_comb begin
    mag   = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
    mag_r = mag[MW-1:0] + MW'(icf_pkg::ROUND_HALF);
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      prod_q    <= prod_d;
      b1_last_q <= item_i.last;
    end
    if (b2_rdy && b1_valid_q) begin
      for (int a = 0; a < 3; a++) begin
        rs_q[a] <= RS'(prod_q[a][0]) + RS'(prod_q[a][1]) + RS'(prod_q[a][2]);
      end
      b2_last_q <= b1_last_q;
    end
    if (b3_rdy && b2_valid_q) begin
      sum_q     <= SW'(rs_q[0]) + SW'(rs_q[1]) + SW'(rs_q[2]);
      b3_last_q <= b2_last_q;
    end
    if (out_rdy && b3_valid_q) begin
      filt_q     <= mag_r[MW-1:icf_pkg::FRAC_W];
      out_last_q <= b3_last_q;
    end
  end

  assign m_tvalid_o  = out_valid_q;
  assign filtered_o  = filt_q;
  assign frame_end_o = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/image_convolution_filter.sv =====
// Throughput: one pixel per cycle sustained while m_axis_tready stays high; the line store
// has one read and one write port, used once per pixel, and the multiply/add back end is
// fully pipelined. Reset (rst_ni, async, active low) clears position, pipeline valids and
// the configuration registers (K=3, zero coefficients, 1024x1024). The line store is not
// cleared; no clearing pass, the block accepts pixels right after reset.
`default_nettype none

`include "assert_macros.svh"

module image_convolution_filter #(
  parameter int MAX_WIDTH  = icf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = icf_pkg::MAX_KERNEL_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // pixel stream in
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,   // [7:0] pixel
  // filtered stream out
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [23:0]                            m_axis_tdata,   // [18:0] filtered, rest 0
  output logic                                   m_axis_tlast,   // frame_end
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [icf_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [icf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [icf_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  localparam int DW  = icf_pkg::APB_DATA_W;
  localparam int IW  = $bits(icf_pkg::icf_item_t);
  localparam int QD  = icf_pkg::QUEUE_DEPTH;

  // ---------------------------------------------------------------------------
  // Configuration registers. Register i sits at byte address 8*i; the low three
  // address bits are ignored and writes to unused indexes are dropped.
  // ---------------------------------------------------------------------------
  logic [icf_pkg::KSIZE_W-1:0]   ksize_q;
  icf_pkg::icf_coef_t            coef_q;
  logic [icf_pkg::CFG_DIM_W-1:0] width_q, height_q;
  icf_pkg::icf_reg_e             reg_idx;
  logic                          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = icf_pkg::icf_reg_e'(paddr[icf_pkg::APB_ADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksize_q  <= icf_pkg::KSIZE_RST;
      coef_q   <= '0;
      width_q  <= icf_pkg::WIDTH_RST;
      height_q <= icf_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        icf_pkg::REG_KSIZE:    ksize_q   <= pwdata[icf_pkg::KSIZE_W-1:0];
        icf_pkg::REG_COEF_TOP: coef_q[0] <= pwdata[3*icf_pkg::COEF_W-1:0];
        icf_pkg::REG_COEF_MID: coef_q[1] <= pwdata[3*icf_pkg::COEF_W-1:0];
        icf_pkg::REG_COEF_BOT: coef_q[2] <= pwdata[3*icf_pkg::COEF_W-1:0];
        icf_pkg::REG_WIDTH:    width_q   <= pwdata[icf_pkg::CFG_DIM_W-1:0];
        icf_pkg::REG_HEIGHT:   height_q  <= pwdata[icf_pkg::CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      icf_pkg::REG_KSIZE:    prdata = DW'(ksize_q);
      icf_pkg::REG_COEF_TOP: prdata = DW'(coef_q[0]);
      icf_pkg::REG_COEF_MID: prdata = DW'(coef_q[1]);
      icf_pkg::REG_COEF_BOT: prdata = DW'(coef_q[2]);
      icf_pkg::REG_WIDTH:    prdata = DW'(width_q);
      icf_pkg::REG_HEIGHT:   prdata = DW'(height_q);
      default:               prdata = '0;
    endcase
  end

  icf_pkg::icf_geom_t geom;
  icf_pkg::icf_kern_t kern;

  assign geom.width  = width_q;
  assign geom.height = height_q;
  assign kern.ksize  = ksize_q;
  assign kern.coef   = coef_q;

  // ---------------------------------------------------------------------------
  // Front end: takes pixels, tracks the raster position, reads the two rows
  // above from the line store and shifts the 3x3 window (clamped at the top
  // and left edges). One finished window per request goes into the queue.
  // ---------------------------------------------------------------------------
  logic               q_push, q_pop, q_full, q_empty;
  logic [$clog2(QD+1)-1:0] q_count;
  icf_pkg::icf_item_t front_item, back_item;
  logic [IW-1:0]      q_rdata;

  icf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .geom_i     (geom),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .pixel_i    (s_axis_tdata),
    .push_o     (q_push),
    .full_i     (q_full),
    .item_o     (front_item)
  );

  // Window queue: lets the front keep taking pixels while the output stalls.
  icf_queue #(
    .WIDTH (IW),
    .DEPTH (QD)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (front_item),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  assign back_item = q_rdata;

  // ---------------------------------------------------------------------------
  // Back end: products, row sums, total, round half away from zero on the
  // magnitude, then the output register that holds a result under backpressure.
  // ---------------------------------------------------------------------------
  logic [icf_pkg::FILT_W-1:0] filtered;

  icf_back #(
    .MAX_KERNEL (MAX_KERNEL)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kern_i      (kern),
    .q_valid_i   (!q_empty),
    .q_pop_o     (q_pop),
    .item_i      (back_item),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .filtered_o  (filtered),
    .frame_end_o (m_axis_tlast)
  );

  assign m_axis_tdata = {{(24 - icf_pkg::FILT_W){1'b0}}, filtered};

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  logic q_grow;

  assign q_grow = q_push && !q_pop;

  // input only stalls when the front holds a request and the queue is full
  `ICF_ASSERT(a_stall_on_full, clk_i, rst_ni, !s_axis_tready |-> q_full, "stall with queue room")
  `ICF_ASSERT(a_q_fill, clk_i, rst_ni, q_grow |=> q_count == $past(q_count) + 1'b1, "fill count")
  `ICF_ASSERT(a_pop_nonempty, clk_i, rst_ni, q_pop |-> (q_count != '0), "pop from empty queue")
  // output flops are only known after the first reset edge
  `ICF_ASSERT_NR(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid, "result valid during reset")

endmodule

`default_nettype wire

// ===== tb/image_convolution_filter_tb.sv =====
// Self-checking testbench for image_convolution_filter: pixel stream in, filtered stream out,
// registers set over the APB port. Predicts every result with its own model of the window.
// Depends on icf_pkg and the image_convolution_filter RTL only.
`default_nettype none

module image_convolution_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import icf_pkg::*;

  localparam int ROW_BITS      = 3 * COEF_W;  // one packed kernel row
  localparam int REG_STRIDE    = 8;           // 64-bit registers sit at 8*i
  localparam int OUT_TDATA_W   = 24;
  localparam int SETTLE_CYCLES = 10;          // covers the pipeline depth with slack
  localparam int DRAIN_LIMIT   = 60000;
  localparam int TAIL_CYCLES   = 20;
  localparam int RAND_ITEMS    = 660;
  localparam int SHORT_RUN     = 40;          // pixels before a mid-frame shrink
  localparam int TALL_ROWS     = 64;          // rows of the one-column frame

  typedef struct packed {
    logic [FILT_W-1:0] filtered;
    logic              frame_end;
  } filt_res_t;

  // receiver back-pressure patterns
  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_CHOKED} rx_mode_e;

  // ---------------------------------------------------------------- DUT signals
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata = '0;   // [7:0] pixel
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;       // [18:0] filtered, [23:19] zero
  logic                  m_axis_tlast;        // frame_end
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  image_convolution_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor state
  bit [KSIZE_W-1:0]   cfg_ksize  = KSIZE_RST;
  bit [ROW_BITS-1:0]  cfg_coef [3];
  bit [CFG_DIM_W-1:0] cfg_width  = WIDTH_RST;
  bit [CFG_DIM_W-1:0] cfg_height = HEIGHT_RST;

  bit [PIX_W-1:0] line_mem [2*MAX_WIDTH_DEF];  // two rows, picked by row parity
  bit [PIX_W-1:0] win_px [3][3];               // [a][b]: pixel at row-a, col-b
  int             row_pos = 0;
  int             col_pos = 0;

  logic [PIX_W-1:0] pixel_q [$];     // pixels waiting to be sent
  filt_res_t        due_q [$];       // filtered values the block still owes us
  int               err_cnt = 0;

  function automatic int eff_dim(bit [CFG_DIM_W-1:0] v, int lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  // One pixel in, one filtered value out; advances the raster position.
  function automatic filt_res_t filter_pixel(logic [PIX_W-1:0] px);
    int w, h, col, k, off, slot_cur, slot_prev, a, i, j;
    bit [PIX_W-1:0] fresh [3];
    bit signed [COEF_W-1:0] c;
    longint acc, mag;
    filt_res_t res;
    w = eff_dim(cfg_width, MAX_WIDTH_DEF);
    h = eff_dim(cfg_height, MAX_HEIGHT);
    col = (col_pos >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : col_pos;
    slot_cur  = (row_pos % 2) * MAX_WIDTH_DEF + col;
    slot_prev = ((row_pos + 1) % 2) * MAX_WIDTH_DEF + col;

    // rows above, replicated at the top edge
    fresh[0] = px;
    if (row_pos == 0) begin
      fresh[1] = px;
      fresh[2] = px;
    end else begin
      fresh[1] = line_mem[slot_prev];
      fresh[2] = (row_pos == 1) ? fresh[1] : line_mem[slot_cur];
    end
    line_mem[slot_cur] = px;

    // shift the window; first column of a row fills it with copies
    for (a = 0; a < 3; a++) begin
      if (col_pos == 0) begin
        win_px[a][0] = fresh[a];
        win_px[a][1] = fresh[a];
        win_px[a][2] = fresh[a];
      end else begin
        win_px[a][2] = win_px[a][1];
        win_px[a][1] = win_px[a][0];
        win_px[a][0] = fresh[a];
      end
    end

    k = (cfg_ksize > MAX_KERNEL_DEF) ? MAX_KERNEL_DEF : int'(cfg_ksize);
    off = (k + 1) / 2;
    acc = 0;
    for (i = 0; i < k; i++) begin
      for (j = 0; j < k; j++) begin
        c = cfg_coef[i][COEF_W*j +: COEF_W];
        acc += longint'(win_px[off-i][off-j]) * longint'(c);
      end
    end
    mag = (acc < 0) ? -acc : acc;
    mag = (mag + ROUND_HALF) >> FRAC_W;
    res.filtered = mag[FILT_W-1:0];

    res.frame_end = 1'b0;
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
        res.frame_end = 1'b1;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- driver
  logic pix_fire = 1'b0;   // request taken at the last rising edge
  int   burst_left = 1;
  int   gap_left = 0;

  always @(negedge clk_i) begin
    if (!s_axis_tvalid || pix_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pixel_q.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: picks a new stall pattern when the current run of random length ends
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     m_axis_tready <= 1'b1;
      RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: m_axis_tready <= ((rx_tick % 7) < 4);
      default:     m_axis_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // ---------------------------------------------------------------- monitor
  filt_res_t want;

  always @(posedge clk_i) begin
    pix_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) due_q.push_back(filter_pixel(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_q.size() == 0) begin
          $error("unexpected result: filtered=%0d frame_end=%0b",
                 m_axis_tdata[FILT_W-1:0], m_axis_tlast);
          err_cnt++;
        end else begin
          want = due_q.pop_front();
          if (m_axis_tdata[FILT_W-1:0] !== want.filtered) begin
            $error("filtered: expected %0d, got %0d", want.filtered, m_axis_tdata[FILT_W-1:0]);
            err_cnt++;
          end
          if (m_axis_tdata[OUT_TDATA_W-1:FILT_W] !== '0) begin
            $error("tdata pad: expected 0, got %0h", m_axis_tdata[OUT_TDATA_W-1:FILT_W]);
            err_cnt++;
          end
          if (m_axis_tlast !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, m_axis_tlast);
            err_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers
  // Sender holds off until every owed result has come out and the pipe is empty.
  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((pixel_q.size() != 0 || s_axis_tvalid || due_q.size() != 0)
           && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (guard >= DRAIN_LIMIT) begin
      $error("drain stuck: %0d results still due", due_q.size());
      err_cnt++;
      due_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(int idx, logic [APB_DATA_W-1:0] val);
    wait_idle();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx * REG_STRIDE);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_KSIZE:    cfg_ksize   = val[KSIZE_W-1:0];
      REG_COEF_TOP: cfg_coef[0] = val[ROW_BITS-1:0];
      REG_COEF_MID: cfg_coef[1] = val[ROW_BITS-1:0];
      REG_COEF_BOT: cfg_coef[2] = val[ROW_BITS-1:0];
      REG_WIDTH:    cfg_width   = val[CFG_DIM_W-1:0];
      REG_HEIGHT:   cfg_height  = val[CFG_DIM_W-1:0];
      default: ;
    endcase
  endtask

  // garbage above the register's own bits
  function automatic logic [APB_DATA_W-1:0] with_junk(logic [APB_DATA_W-1:0] v, int w);
    logic [APB_DATA_W-1:0] keep;
    keep = (64'd1 << w) - 64'd1;
    return ({$urandom, $urandom} & ~keep) | (v & keep);
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return COEF_W'(int'($urandom_range(0, 1024)) - 512);
      default: return COEF_W'($urandom);
    endcase
  endfunction

  task automatic write_rand_coefs();
    apb_write(REG_COEF_TOP, with_junk({rand_coef(), rand_coef(), rand_coef()}, ROW_BITS));
    apb_write(REG_COEF_MID, with_junk({rand_coef(), rand_coef(), rand_coef()}, ROW_BITS));
    apb_write(REG_COEF_BOT, with_junk({rand_coef(), rand_coef(), rand_coef()}, ROW_BITS));
  endtask

  task automatic push_pixels(int n);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0:       pixel_q.push_back(8'd0);
        1:       pixel_q.push_back(8'd255);
        default: pixel_q.push_back(PIX_W'($urandom));
      endcase
    end
  endtask

  // ---------------------------------------------------------------- test sequence
  initial begin : stim
    int rand_items, w, h, n, k, frames, half;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // most negative coefficients on a full-white 2x2 frame: largest magnitude
    apb_write(REG_COEF_TOP, with_junk(48'h8000_8000_8000, ROW_BITS));
    apb_write(REG_COEF_MID, with_junk(48'h8000_8000_8000, ROW_BITS));
    apb_write(REG_COEF_BOT, with_junk(48'h8000_8000_8000, ROW_BITS));
    apb_write(REG_KSIZE, with_junk(3, KSIZE_W));
    apb_write(REG_WIDTH, with_junk(2, CFG_DIM_W));
    apb_write(REG_HEIGHT, with_junk(2, CFG_DIM_W));
    repeat (4) pixel_q.push_back(8'd255);

    // most positive coefficients, 2x2 kernel, stripes
    apb_write(REG_COEF_TOP, 48'h7FFF_7FFF_7FFF);
    apb_write(REG_COEF_MID, 48'h7FFF_7FFF_7FFF);
    apb_write(REG_COEF_BOT, 48'h7FFF_7FFF_7FFF);
    apb_write(REG_KSIZE, with_junk(2, KSIZE_W));
    apb_write(REG_WIDTH, 3);
    repeat (3) begin
      pixel_q.push_back(8'd0);
      pixel_q.push_back(8'd255);
    end

    // 1x1 kernel at -0.5: exact halves round away from zero; zero width means one column
    apb_write(REG_COEF_TOP, 48'h0000_0000_FF80);
    apb_write(REG_KSIZE, with_junk(1, KSIZE_W));
    apb_write(REG_WIDTH, with_junk(0, CFG_DIM_W));
    apb_write(REG_HEIGHT, 3);
    pixel_q.push_back(8'd1);
    pixel_q.push_back(8'd3);
    pixel_q.push_back(8'd255);

    // empty kernel gives zero; writes past the register list do nothing
    apb_write(REG_KSIZE, with_junk(0, KSIZE_W));
    apb_write(int'(REG_HEIGHT) + 1, with_junk(0, 0));
    apb_write(int'(REG_HEIGHT) + 2, with_junk(0, 0));
    apb_write(REG_WIDTH, 2);
    apb_write(REG_HEIGHT, 1);
    repeat (2) pixel_q.push_back(8'd255);

    // oversize width; then shrink width and height mid-frame,
    // which leaves the position beyond the new size until the next wrap
    write_rand_coefs();
    apb_write(REG_KSIZE, 3);
    apb_write(REG_WIDTH, with_junk(11'h7FF, CFG_DIM_W));
    apb_write(REG_HEIGHT, MAX_HEIGHT);
    push_pixels(SHORT_RUN);
    apb_write(REG_WIDTH, 4);
    apb_write(REG_HEIGHT, 0);
    push_pixels(1);

    // one pixel wide, oversize height, cut short by a height shrink
    write_rand_coefs();
    apb_write(REG_WIDTH, 0);
    apb_write(REG_HEIGHT, 11'h7FF);
    push_pixels(TALL_ROWS);
    apb_write(REG_HEIGHT, 1);
    push_pixels(1);

    // random phases: geometry changes only at frame boundaries
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       k = 0;
        1:       k = 1;
        2, 3:    k = 2;
        default: k = 3;
      endcase
      if ($urandom_range(0, 3) != 0) apb_write(REG_KSIZE, with_junk(k, KSIZE_W));
      if ($urandom_range(0, 2) != 0) write_rand_coefs();
      if ($urandom_range(0, 7) == 0)
        apb_write(int'(REG_HEIGHT) + 1 + $urandom_range(0, 1), with_junk(0, 0));
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 5);
      apb_write(REG_WIDTH,
                with_junk((w == 1 && $urandom_range(0, 1) == 0) ? 0 : w, CFG_DIM_W));
      apb_write(REG_HEIGHT,
                with_junk((h == 1 && $urandom_range(0, 1) == 0) ? 0 : h, CFG_DIM_W));
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        n = w * h;
        if (n > 1 && $urandom_range(0, 3) == 0) begin
          // kernel change in the middle of a frame must not move the position
          half = n / 2;
          push_pixels(half);
          if ($urandom_range(0, 1) == 0) apb_write(REG_KSIZE, $urandom_range(0, 3));
          else apb_write(REG_COEF_MID, {rand_coef(), rand_coef(), rand_coef()});
          push_pixels(n - half);
        end else begin
          push_pixels(n);
        end
        rand_items += n;
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("image_convolution_filter_tb passed");
    end else begin
      $display("image_convolution_filter_tb failed");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("image_convolution_filter_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
